/* hdl/touch_sample_qualifier_filter_top_assert.svh */
// Assertion macros shared by the touch sample qualifier RTL.
// Included by the modules that check their own invariants; no other dependencies.
`ifndef TOUCH_SAMPLE_QUALIFIER_FILTER_TOP_ASSERT_SVH
`define TOUCH_SAMPLE_QUALIFIER_FILTER_TOP_ASSERT_SVH
`ifndef SYNTH
// Condition must hold at every clock edge outside reset.
`define TSQF_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("tsqf invariant violated");
// Consequent must hold in the cycle after the antecedent.
`define TSQF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsqf sequence violated");
`else
`define TSQF_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TSQF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/tsqf_pkg.sv */
// Types, codes, constants and helper functions of the touch sample qualifier.
// No dependencies; used by the front end, queue, back end and top module.
package tsqf_pkg;

   localparam int COORD_W = 12;
   localparam logic [COORD_W-1:0] COORD_MAX = 12'hfff;
   localparam logic [COORD_W-1:0] STEP_LIMIT_RESET = 12'h060;
   localparam logic [COORD_W-1:0] STABLE_LIMIT = 12'd6;
   localparam logic [COORD_W-1:0] MOVE_THRESHOLD = 12'd5;
   localparam logic [1:0] MOVE_SAT = 2'd3;
   localparam logic [1:0] RETRY_LIMIT = 2'd3;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [0:0] CSR_STEP_LIMIT = 1'b0;
   localparam logic [0:0] CSR_DEVICE_OPEN = 1'b1;

   typedef enum logic [1:0] {
      OP_PEN_DOWN = 2'd0,
      OP_PEN_UP   = 2'd1,
      OP_SAMPLE   = 2'd2,
      OP_UNUSED   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PHASE_UP   = 2'd0,
      PHASE_PRE  = 2'd1,
      PHASE_DOWN = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      KIND_POS    = 3'd0,
      KIND_PENUP  = 3'd1,
      KIND_NONE   = 3'd2,
      KIND_RETRY  = 3'd3,
      KIND_FAIL   = 3'd4,
      KIND_IRQ_OK = 3'd5,
      KIND_IRQ_NO = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      WAIT_FULL = 2'd0,
      WAIT_HALF = 2'd1,
      WAIT_LONG = 2'd2,
      WAIT_NONE = 2'd3
   } wait_type;

   typedef struct packed {
      logic [COORD_W-1:0] step_limit;
      logic               device_open;
   } cfg_type;

   // One classified transaction; dual asks for the previous point to be sent first.
   typedef struct packed {
      logic               dual;
      logic [COORD_W-1:0] prev_x;
      logic [COORD_W-1:0] prev_y;
      kind_type           kind;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      wait_type           next_wait;
   } entry_type;

   function automatic logic [COORD_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic logic [COORD_W-1:0] limit_axis(input logic [COORD_W-1:0] v,
                                                     input logic [COORD_W-1:0] last,
                                                     input logic [COORD_W-1:0] step);
      logic [COORD_W:0]   up;
      logic [COORD_W-1:0] res;
      res = v;
      up = {1'b0, last} + {1'b0, step};
      if (last > v) begin
         if ((last - v) > step) begin
            res = last - step;
         end
      end else if ((v - last) > step) begin
         if (up > {1'b0, COORD_MAX}) begin
            res = COORD_MAX;
         end else begin
            res = up[COORD_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

/* hdl/tsqf_if.sv */
// Channel interfaces of the touch sample qualifier: request, response and CSR write.
// Each carries valid, ready and its payload; no dependencies.
interface tsqf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [11:0] x_first;
   logic [11:0] y_first;
   logic [11:0] x_second;
   logic [11:0] y_second;
   modport source(output valid, opcode, x_first, y_first, x_second, y_second,
                  input ready);
   modport sink(input valid, opcode, x_first, y_first, x_second, y_second,
                output ready);
endinterface

interface tsqf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [11:0] x_pos;
   logic [11:0] y_pos;
   logic        touching;
   logic [1:0]  next_wait;
   logic        last_of_run;
   modport source(output valid, kind, x_pos, y_pos, touching, next_wait, last_of_run,
                  input ready);
   modport sink(input valid, kind, x_pos, y_pos, touching, next_wait, last_of_run,
                output ready);
endinterface

interface tsqf_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [11:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* hdl/tsqf_front.sv */
// Front end: accepts request transactions, qualifies sample pairs, filters points
// and updates pen state. Depends on tsqf_pkg, tsqf_if and the assertion header.
`include "touch_sample_qualifier_filter_top_assert.svh"

module tsqf_front (
   input  logic                clock,
   input  logic                reset,
   input  tsqf_pkg::cfg_type   cfg,
   tsqf_req_if.sink            req_chan,
   output logic                push_valid,
   input  logic                push_ready,
   output tsqf_pkg::entry_type push_data
);

   tsqf_pkg::phase_type phase_ff, phase_in;
   logic [11:0] prev_x_ff, prev_x_in;
   logic [11:0] prev_y_ff, prev_y_in;
   logic [1:0]  move_ff, move_in;
   logic [1:0]  fail_ff, fail_in;

   logic        accept;
   logic        stable;
   logic [12:0] sum_x, sum_y;
   logic [11:0] avg_x, avg_y;
   logic        have_prev;
   logic [11:0] lim_x, lim_y;
   logic        jump;
   logic [1:0]  move_next;
   logic [1:0]  fail_bump;

   assign accept = req_chan.valid && push_ready;
   assign push_valid = req_chan.valid;
   assign req_chan.ready = push_ready;

   assign stable = (tsqf_pkg::abs_diff(req_chan.x_first, req_chan.x_second)
                    < tsqf_pkg::STABLE_LIMIT) &&
                   (tsqf_pkg::abs_diff(req_chan.y_first, req_chan.y_second)
                    < tsqf_pkg::STABLE_LIMIT);
   assign sum_x = {1'b0, req_chan.x_first} + {1'b0, req_chan.x_second};
   assign sum_y = {1'b0, req_chan.y_first} + {1'b0, req_chan.y_second};
   assign avg_x = sum_x[12:1];
   assign avg_y = sum_y[12:1];
   assign have_prev = (prev_x_ff != '0) || (prev_y_ff != '0);

   // Step limiting applies only against a real previous point and a nonzero step_limit.
   assign lim_x = (have_prev && cfg.step_limit != '0) ?
                  tsqf_pkg::limit_axis(avg_x, prev_x_ff, cfg.step_limit) : avg_x;
   assign lim_y = (have_prev && cfg.step_limit != '0) ?
                  tsqf_pkg::limit_axis(avg_y, prev_y_ff, cfg.step_limit) : avg_y;

   assign jump = (tsqf_pkg::abs_diff(prev_x_ff, lim_x) > tsqf_pkg::MOVE_THRESHOLD) ||
                 (tsqf_pkg::abs_diff(prev_y_ff, lim_y) > tsqf_pkg::MOVE_THRESHOLD);
   assign move_next = !have_prev ? move_ff :
                      !jump ? 2'd0 :
                      (move_ff == tsqf_pkg::MOVE_SAT) ? move_ff : move_ff + 2'd1;
   assign fail_bump = fail_ff + 2'd1;

   always_comb begin
      phase_in = phase_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      move_in = move_ff;
      fail_in = '0;
      push_data.dual = 1'b0;
      push_data.prev_x = prev_x_ff;
      push_data.prev_y = prev_y_ff;
      push_data.kind = tsqf_pkg::KIND_NONE;
      push_data.x = '0;
      push_data.y = '0;
      push_data.next_wait = tsqf_pkg::WAIT_NONE;
      unique case (tsqf_pkg::op_type'(req_chan.opcode))
         tsqf_pkg::OP_PEN_DOWN: begin
            if (cfg.device_open && phase_ff == tsqf_pkg::PHASE_UP) begin
               phase_in = tsqf_pkg::PHASE_PRE;
               push_data.kind = tsqf_pkg::KIND_IRQ_OK;
               push_data.next_wait = tsqf_pkg::WAIT_HALF;
            end else begin
               push_data.kind = tsqf_pkg::KIND_IRQ_NO;
            end
         end
         tsqf_pkg::OP_PEN_UP: begin
            priority if (phase_ff == tsqf_pkg::PHASE_DOWN) begin
               phase_in = tsqf_pkg::PHASE_UP;
               prev_x_in = '0;
               prev_y_in = '0;
               move_in = '0;
               push_data.kind = tsqf_pkg::KIND_PENUP;
               push_data.next_wait = tsqf_pkg::WAIT_LONG;
            end else if (phase_ff == tsqf_pkg::PHASE_PRE) begin
               phase_in = tsqf_pkg::PHASE_UP;
               push_data.next_wait = tsqf_pkg::WAIT_LONG;
            end else begin
               push_data.next_wait = tsqf_pkg::WAIT_NONE;
            end
         end
         tsqf_pkg::OP_SAMPLE: begin
            if (!stable) begin
               if (fail_bump >= tsqf_pkg::RETRY_LIMIT) begin
                  // Too many unstable pairs in a row: drop the point history.
                  prev_x_in = '0;
                  prev_y_in = '0;
                  move_in = '0;
                  push_data.kind = tsqf_pkg::KIND_FAIL;
                  push_data.next_wait = tsqf_pkg::WAIT_FULL;
               end else begin
                  fail_in = fail_bump;
                  push_data.kind = tsqf_pkg::KIND_RETRY;
               end
            end else begin
               if (phase_ff == tsqf_pkg::PHASE_PRE) begin
                  phase_in = tsqf_pkg::PHASE_DOWN;
               end
               move_in = move_next;
               prev_x_in = lim_x;
               prev_y_in = lim_y;
               if (move_next == 2'd1) begin
                  push_data.next_wait = tsqf_pkg::WAIT_HALF;
               end else begin
                  push_data.dual = (move_next == 2'd2);
                  push_data.kind = tsqf_pkg::KIND_POS;
                  push_data.x = lim_x;
                  push_data.y = lim_y;
                  push_data.next_wait = tsqf_pkg::WAIT_FULL;
               end
            end
         end
         tsqf_pkg::OP_UNUSED: begin
            push_data.kind = tsqf_pkg::KIND_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= tsqf_pkg::PHASE_UP;
         prev_x_ff <= '0;
         prev_y_ff <= '0;
         move_ff <= '0;
         fail_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         prev_x_ff <= prev_x_in;
         prev_y_ff <= prev_y_in;
         move_ff <= move_in;
         fail_ff <= fail_in;
      end
   end

   `TSQF_ASSERT_ALWAYS(a_fail_below_limit, clock, reset, fail_ff < tsqf_pkg::RETRY_LIMIT)

endmodule

/* hdl/tsqf_queue.sv */
// Short queue of classified transactions between the front and back ends.
// Depends on tsqf_pkg and the assertion header.
`include "touch_sample_qualifier_filter_top_assert.svh"

module tsqf_queue #(
   parameter int DEPTH = tsqf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tsqf_pkg::entry_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tsqf_pkg::entry_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsqf_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   `TSQF_ASSERT_ALWAYS(a_count_bounded, clock, reset, count_ff <= CNT_W'(DEPTH))
   `TSQF_ASSERT_NEXT(a_push_counts, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

/* hdl/tsqf_back.sv */
// Back end: turns queued transactions into one or two response transactions
// through a registered output stage. Depends on tsqf_pkg, tsqf_if and the assertion header.
`include "touch_sample_qualifier_filter_top_assert.svh"

module tsqf_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  tsqf_pkg::entry_type pop_data,
   tsqf_rsp_if.source          rsp_chan
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic               half_ff, half_in;
   tsqf_pkg::kind_type kind_ff;
   logic [11:0]        x_ff, y_ff;
   logic               touch_ff;
   tsqf_pkg::wait_type wait_ff;
   logic               last_ff;

   logic load;
   logic send_prev;

   assign load = !rsp_valid_ff || rsp_chan.ready;
   // A dual entry first sends the previous point and stays at the queue head.
   assign send_prev = pop_data.dual && !half_ff;
   assign pop_ready = load && !send_prev;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      half_in = half_ff;
      if (load) begin
         rsp_valid_in = pop_valid;
         if (pop_valid) begin
            half_in = send_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         half_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         half_ff <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && pop_valid) begin
         if (send_prev) begin
            kind_ff <= tsqf_pkg::KIND_POS;
            x_ff <= pop_data.prev_x;
            y_ff <= pop_data.prev_y;
            touch_ff <= 1'b1;
            wait_ff <= tsqf_pkg::WAIT_NONE;
            last_ff <= 1'b0;
         end else begin
            kind_ff <= pop_data.kind;
            x_ff <= pop_data.x;
            y_ff <= pop_data.y;
            touch_ff <= (pop_data.kind == tsqf_pkg::KIND_POS);
            wait_ff <= pop_data.next_wait;
            last_ff <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.kind = kind_ff;
   assign rsp_chan.x_pos = x_ff;
   assign rsp_chan.y_pos = y_ff;
   assign rsp_chan.touching = touch_ff;
   assign rsp_chan.next_wait = wait_ff;
   assign rsp_chan.last_of_run = last_ff;

   `TSQF_ASSERT_ALWAYS(a_half_holds_head, clock, reset, !half_ff || (pop_valid && pop_data.dual))
   `TSQF_ASSERT_NEXT(a_half_then_last, clock, reset, load && pop_valid && half_ff, rsp_valid_ff && last_ff)

endmodule

/* hdl/touch_sample_qualifier_filter_top.sv */
// A response becomes valid once its request has passed through the queue and the output register.
// Throughput: one request per cycle while the queue has room; a request whose point is reported twice
// holds the output register for two responses, so the back end can lower the rate.
// The queue between front and back end lets requests keep flowing while responses stall.
// Synchronous reset clears pen state, point history, the queue and the output stage;
// step_limit returns to 96 and device_open to 0.
module touch_sample_qualifier_filter_top #(
   parameter int QUEUE_DEPTH = tsqf_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tsqf_req_if.sink   req_chan,
   tsqf_rsp_if.source rsp_chan,
   tsqf_csr_if.sink   csr_chan
);

   logic [11:0] step_limit_ff;
   logic        device_open_ff;
   tsqf_pkg::cfg_type   cfg;
   logic                push_valid, push_ready;
   tsqf_pkg::entry_type push_data;
   logic                pop_valid, pop_ready;
   tsqf_pkg::entry_type pop_data;

   assign csr_chan.ready = 1'b1;
   assign cfg.step_limit = step_limit_ff;
   assign cfg.device_open = device_open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_limit_ff <= tsqf_pkg::STEP_LIMIT_RESET;
         device_open_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            tsqf_pkg::CSR_STEP_LIMIT: step_limit_ff <= csr_chan.data;
            tsqf_pkg::CSR_DEVICE_OPEN: device_open_ff <= csr_chan.data[0];
         endcase
      end
   end

   tsqf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tsqf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tsqf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
